@@ sv/pws_pkg.sv @@
package pws_pkg;

  // request type codes
  localparam logic [1:0] REQ_GRADED = 2'd0;
  localparam logic [1:0] REQ_PLAIN  = 2'd1;
  localparam logic [1:0] REQ_BLEND  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_BRIGHT = 2'd2;
  localparam logic [1:0] CFG_NIGHT  = 2'd3;

  localparam logic [12:0] WIDTH_RST  = 13'd1024;
  localparam logic [12:0] HEIGHT_RST = 13'd768;
  localparam logic [6:0]  PCT_FULL   = 7'd100;
  localparam logic [6:0]  PCT_MIN    = 7'd10;
  localparam logic [6:0]  RED_GAIN   = 7'd110;
  localparam logic [6:0]  BLUE_GAIN  = 7'd65;
  localparam logic [7:0]  CHAN_MAX   = 8'd255;

  // floor(v/100) == (v*5243)>>19, exact for v below 28672
  localparam logic [12:0] RECIP100   = 13'd5243;
  localparam int          RECIP_SH   = 19;

  typedef struct packed {
    logic wr;     // pixel is written
    logic blend;  // alpha mix instead of shading
    logic tint;   // night-light tint applies
  } pws_mode_t;

  function automatic logic [8:0] div100(input logic [14:0] v);
    logic [27:0] prod;
    prod = 28'(v) * 28'(RECIP100);
    return prod[RECIP_SH+8:RECIP_SH];
  endfunction

endpackage

@@ sv/pws_color_pipe.sv @@
module pws_color_pipe (
  input  logic              clk,
  input  pws_pkg::pws_mode_t in_mode,
  input  logic [23:0]       in_src,
  input  logic [23:0]       in_dst,
  input  logic [7:0]        in_alpha,
  input  logic [6:0]        in_pct,
  output logic [23:0]       out_color
);
  import pws_pkg::*;

  // stage 2: brightness and blend products
  pws_mode_t         mode2_r;
  logic [2:0][14:0]  br_prod_r, br_prod_nxt;
  logic [2:0][15:0]  mix_s_r, mix_s_nxt;
  logic [2:0][15:0]  mix_d_r, mix_d_nxt;
  // stage 3: shaded or mixed channels
  pws_mode_t         mode3_r;
  logic [2:0][7:0]   chan3_r, chan3_nxt;
  // stage 4: tint products
  pws_mode_t         mode4_r;
  logic [2:0][14:0]  prod4_r, prod4_nxt;
  // stage 5: packed color
  logic [23:0]       color5_r, color5_nxt;

  logic [7:0] inv_alpha;
  assign inv_alpha = CHAN_MAX - in_alpha;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      br_prod_nxt[ch] = 15'(in_src[ch*8 +: 8]) * 15'(in_pct);
      mix_s_nxt[ch]   = 16'(in_src[ch*8 +: 8]) * 16'(in_alpha);
      mix_d_nxt[ch]   = 16'(in_dst[ch*8 +: 8]) * 16'(inv_alpha);
    end
  end

  always_comb begin
    logic [15:0] sum;
    logic [8:0]  q;
    for (int ch = 0; ch < 3; ch++) begin
      sum = mix_s_r[ch] + mix_d_r[ch];
      q   = div100(br_prod_r[ch]);
      chan3_nxt[ch] = mode2_r.blend ? sum[15:8] : q[7:0];
    end
  end

  // unity gain (x100, then /100) where no tint
  always_comb begin
    prod4_nxt[2] = 15'(chan3_r[2]) * 15'(mode3_r.tint ? RED_GAIN : PCT_FULL);
    prod4_nxt[1] = 15'(chan3_r[1]) * 15'(PCT_FULL);
    prod4_nxt[0] = 15'(chan3_r[0]) * 15'(mode3_r.tint ? BLUE_GAIN : PCT_FULL);
  end

  always_comb begin
    logic [8:0] q;
    color5_nxt = '0;
    for (int ch = 0; ch < 3; ch++) begin
      q = div100(prod4_r[ch]);
      // saturate; only red can exceed 255
      color5_nxt[ch*8 +: 8] = q[8] ? CHAN_MAX : q[7:0];
    end
    if (!mode4_r.wr) begin
      color5_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    mode2_r   <= in_mode;
    br_prod_r <= br_prod_nxt;
    mix_s_r   <= mix_s_nxt;
    mix_d_r   <= mix_d_nxt;
    mode3_r   <= mode2_r;
    chan3_r   <= chan3_nxt;
    mode4_r   <= mode3_r;
    prod4_r   <= prod4_nxt;
    color5_r  <= color5_nxt;
  end

  assign out_color = color5_r;

endmodule

@@ sv/pixel_write_stage_core.sv @@
// Pixel write stage: clip, linear address and color shading/blending.
// Output: a transaction accepted at one clock edge passes through the registered
//   pipeline stages and is presented on the out_ ports for one cycle, marked by out_strobe.
// Throughput: one transaction per clock; busy stays low, the receiver cannot stall.
// Reset (rst_n low, synchronous) clears all valid bits and loads the register
//   defaults: width 1024, height 768, brightness 100, night light off.
module pixel_write_stage_core (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic signed [12:0] in_pos_x,
  input  logic signed [12:0] in_pos_y,
  input  logic [23:0] in_src_color,
  input  logic [7:0]  in_alpha,
  input  logic [23:0] in_dst_color,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // result transaction
  output logic        out_strobe,
  output logic        out_write_enable,
  output logic [23:0] out_pixel_address,
  output logic [23:0] out_pixel_color
);
  import pws_pkg::*;

  // configuration registers
  logic [12:0] width_r;
  logic [12:0] height_r;
  logic [6:0]  bright_r;
  logic        night_r;
  logic [6:0]  pct_eff;

  // stage 1: captured and decoded transaction
  logic        vld1_r;
  logic        we1_r, we1_nxt;
  pws_mode_t   mode1_r, mode1_nxt;
  logic [11:0] x1_r, y1_r;
  logic [23:0] src1_r, dst1_r;
  logic [7:0]  alpha1_r;

  // address path, stages 2 to 5
  logic        vld2_r, vld3_r, vld4_r, vld5_r;
  logic        we2_r, we3_r, we4_r, we5_r;
  logic [11:0] x2_r;
  logic [24:0] row2_nxt;
  logic [23:0] row2_r;
  logic [23:0] addr3_r, addr4_r, addr5_r;

  logic [23:0] color;
  logic        accept;

  // no backpressure anywhere in the pipe
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Configuration: write on enable, no handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      bright_r <= PCT_FULL;
      night_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_BRIGHT: bright_r <= cfg_data[6:0];
        CFG_NIGHT:  night_r  <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Clamp brightness: at or above full means unchanged (scale by 100/100),
  // below the floor behaves as the floor.
  always_comb begin
    if (bright_r >= PCT_FULL) begin
      pct_eff = PCT_FULL;
    end else if (bright_r < PCT_MIN) begin
      pct_eff = PCT_MIN;
    end else begin
      pct_eff = bright_r;
    end
  end

  // Stage 1 decode: clip against the screen, pick the color mode.
  always_comb begin
    logic inside_scr;
    inside_scr = !in_pos_x[12] && !in_pos_y[12]
              && (in_pos_x < $signed({1'b0, width_r}))
              && (in_pos_y < $signed({1'b0, height_r}));
    mode1_nxt = '0;
    unique case (in_req_type)
      REQ_GRADED: begin
        we1_nxt        = inside_scr;
        mode1_nxt.tint = night_r;
      end
      REQ_PLAIN: begin
        we1_nxt = inside_scr;
      end
      REQ_BLEND: begin
        // transparent writes nothing; opaque shades like a plain write
        we1_nxt         = inside_scr && (in_alpha != 8'd0);
        mode1_nxt.blend = (in_alpha != CHAN_MAX);
      end
      default: begin
        we1_nxt = 1'b0;
      end
    endcase
    mode1_nxt.wr = we1_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= accept;
    end
  end

  // payload captures unconditionally; vld1_r qualifies it
  always_ff @(posedge clk) begin
    we1_r    <= we1_nxt;
    mode1_r  <= mode1_nxt;
    x1_r     <= in_pos_x[11:0];
    y1_r     <= in_pos_y[11:0];
    src1_r   <= in_src_color;
    dst1_r   <= in_dst_color;
    alpha1_r <= in_alpha;
  end

  // Address: row offset multiply in stage 2, add column in stage 3.
  assign row2_nxt = 25'(y1_r) * 25'(width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
    end
  end

  always_ff @(posedge clk) begin
    we2_r   <= we1_r;
    x2_r    <= x1_r;
    row2_r  <= row2_nxt[23:0];
    we3_r   <= we2_r;
    addr3_r <= row2_r + 24'(x2_r);
    we4_r   <= we3_r;
    addr4_r <= addr3_r;
    we5_r   <= we4_r;
    // drop the address of a suppressed write
    addr5_r <= we4_r ? addr4_r : 24'd0;
  end

  // Color path runs alongside, stages 2 to 5, zeroed when no write.
  pws_color_pipe u_color (
    .clk       (clk),
    .in_mode   (mode1_r),
    .in_src    (src1_r),
    .in_dst    (dst1_r),
    .in_alpha  (alpha1_r),
    .in_pct    (pct_eff),
    .out_color (color)
  );

  assign out_strobe        = vld5_r;
  assign out_write_enable  = we5_r;
  assign out_pixel_address = addr5_r;
  assign out_pixel_color   = color;

endmodule
